// ===== design/oal_pkg.sv =====
// Shared constants, codes and types for the ordered array list.
`timescale 1ns / 1ps

package oal_pkg;

    localparam int ADDR_W   = 8;
    localparam int CAPACITY = 1 << ADDR_W;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [ST_W-1:0]   t_status;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [DATA_W-1:0] t_data;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_SEARCH = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_RANGE    = 2'd1;
    localparam t_status ST_NOTFOUND = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

    localparam t_count CAP_COUNT = t_count'(CAPACITY);

    typedef struct packed {
        t_op   operation;
        t_addr position;
        t_data item_value;
    } t_req;

    typedef struct packed {
        t_status status;
        t_addr   found_index;
        t_data   removed_value;
        t_count  list_length;
    } t_res;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

endpackage

// ===== design/oal_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps

interface oal_req_if;
    logic              valid;
    logic              ready;
    oal_pkg::t_op      operation;
    oal_pkg::t_addr    position;
    oal_pkg::t_data    item_value;

    modport source (output valid, output operation, output position,
                    output item_value, input ready);
    modport sink   (input valid, input operation, input position,
                    input item_value, output ready);
endinterface

interface oal_res_if;
    logic              valid;
    logic              ready;
    oal_pkg::t_status  status;
    oal_pkg::t_addr    found_index;
    oal_pkg::t_data    removed_value;
    oal_pkg::t_count   list_length;

    modport source (output valid, output status, output found_index,
                    output removed_value, output list_length, input ready);
    modport sink   (input valid, input status, input found_index,
                    input removed_value, input list_length, output ready);
endinterface

// ===== design/oal_store.sv =====
// List storage: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module oal_store (
    input  logic              i_clk,
    input  oal_pkg::t_mem_req i_mem,
    output oal_pkg::t_data    o_rdata
);

    oal_pkg::t_data r_mem [oal_pkg::CAPACITY];
    oal_pkg::t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem.re) begin
            r_rdata <= r_mem[i_mem.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/oal_ctrl.sv =====
// Request sequencer: walks the list store one entry per cycle.
`timescale 1ns / 1ps

module oal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  oal_pkg::t_req     i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output oal_pkg::t_res     o_res,
    output oal_pkg::t_mem_req o_mem,
    input  oal_pkg::t_data    i_mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH,
        S_DONE
    } t_state;

    t_state           r_state,   n_state;
    oal_pkg::t_op     r_op,      n_op;
    oal_pkg::t_addr   r_pos,     n_pos;
    oal_pkg::t_data   r_val,     n_val;
    oal_pkg::t_count  r_count,   n_count;
    oal_pkg::t_count  r_ptr,     n_ptr;
    oal_pkg::t_count  r_remain,  n_remain;
    logic             r_pend,    n_pend;
    oal_pkg::t_addr   r_pend_addr, n_pend_addr;
    oal_pkg::t_status r_status,  n_status;
    oal_pkg::t_addr   r_found,   n_found;
    oal_pkg::t_data   r_removed, n_removed;

    oal_pkg::t_count  req_pos;
    logic             hit;

    assign req_pos = {1'b0, i_req.position};

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_remain    = r_remain;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_status    = r_status;
        n_found     = r_found;
        n_removed   = r_removed;
        hit         = 1'b0;
        o_mem       = '0;

        unique case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
                if (i_req_valid) begin
                    n_op      = i_req.operation;
                    n_pos     = i_req.position;
                    n_val     = i_req.item_value;
                    n_status  = oal_pkg::ST_OK;
                    n_found   = '0;
                    n_removed = '0;
                    case (i_req.operation)
                        oal_pkg::OP_INSERT: begin
                            if (r_count >= oal_pkg::CAP_COUNT) begin
                                n_status = oal_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else if (req_pos > r_count) begin
                                n_status = oal_pkg::ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_remain = r_count - req_pos;
                                n_ptr    = r_count - 1'b1;
                                n_state  = S_RUN;
                            end
                        end
                        oal_pkg::OP_REMOVE: begin
                            if (req_pos >= r_count) begin
                                n_status = oal_pkg::ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_remain = r_count - req_pos;
                                n_ptr    = req_pos;
                                n_state  = S_RUN;
                            end
                        end
                        oal_pkg::OP_SEARCH: begin
                            n_status = oal_pkg::ST_NOTFOUND;
                            n_remain = r_count;
                            n_ptr    = '0;
                            n_state  = S_RUN;
                        end
                        default: begin
                            n_status = oal_pkg::ST_RANGE;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                // retire the entry read in the previous cycle
                if (r_pend) begin
                    case (r_op)
                        oal_pkg::OP_INSERT: begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_pend_addr + 1'b1;
                            o_mem.wdata = i_mem_rdata;
                        end
                        oal_pkg::OP_REMOVE: begin
                            if (r_pend_addr == r_pos) begin
                                n_removed = i_mem_rdata;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_pend_addr - 1'b1;
                                o_mem.wdata = i_mem_rdata;
                            end
                        end
                        default: begin
                            if (i_mem_rdata == r_val) begin
                                hit = 1'b1;
                            end
                        end
                    endcase
                end
                if (hit) begin
                    n_status = oal_pkg::ST_OK;
                    n_found  = r_pend_addr;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                end else if (r_remain != '0) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_ptr[oal_pkg::ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_pend_addr = r_ptr[oal_pkg::ADDR_W-1:0];
                    n_remain    = r_remain - 1'b1;
                    n_ptr       = (r_op == oal_pkg::OP_INSERT) ? r_ptr - 1'b1 : r_ptr + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    case (r_op)
                        oal_pkg::OP_INSERT: n_state = S_FINISH;
                        oal_pkg::OP_REMOVE: begin
                            n_count = r_count - 1'b1;
                            n_state = S_DONE;
                        end
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_FINISH: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pos;
                o_mem.wdata = r_val;
                n_count     = r_count + 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_ptr       <= n_ptr;
        r_remain    <= n_remain;
        r_pend_addr <= n_pend_addr;
        r_status    <= n_status;
        r_found     <= n_found;
        r_removed   <= n_removed;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status        = r_status;
        o_res.found_index   = r_found;
        o_res.removed_value = r_removed;
        o_res.list_length   = r_count;
    end

endmodule

// ===== design/ordered_array_list.sv =====
// Top level of the ordered array list: sequencer, list store and result register.
// Usage:
//   i_req carries one request per handshake: operation (insert, remove,
//   search), position and item_value. o_res returns exactly one result per
//   request: status, found_index, removed_value and list_length after it.
//   Both channels move a request or result when valid and ready are high at
//   a rising edge of i_clk.
// Timing:
//   The list store has one read and one write port, and the sequencer moves
//   one entry per cycle through it. An insert moves the entries from the end
//   of the list down to position, a remove those from position on, and a
//   search stops at the first match; a refused request goes straight to
//   its result. The sequencer works on one request at a time.
// Reset:
//   i_rst_n (synchronous, active low) empties the list and drops any pending
//   result. The store is not cleared; entries beyond the count are never read.
// Stall:
//   A result waits in the output register while o_res.ready is low; the next
//   request is still taken and worked on, its result held in the sequencer.
`timescale 1ns / 1ps

module ordered_array_list (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oal_req_if.sink   i_req,
    oal_res_if.source o_res
);

    oal_pkg::t_req     req;
    oal_pkg::t_res     ctrl_res;
    logic              ctrl_res_valid;
    logic              ctrl_res_ready;
    oal_pkg::t_mem_req mem_req;
    oal_pkg::t_data    mem_rdata;

    logic              r_out_valid;
    oal_pkg::t_res     r_out;

    // pack the request fields
    always_comb begin
        req.operation  = i_req.operation;
        req.position   = i_req.position;
        req.item_value = i_req.item_value;
    end

    oal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (req),
        .o_res_valid (ctrl_res_valid),
        .i_res_ready (ctrl_res_ready),
        .o_res       (ctrl_res),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    oal_store u_store (
        .i_clk   (i_clk),
        .i_mem   (mem_req),
        .o_rdata (mem_rdata)
    );

    // advance the result register when it is empty or being drained
    assign ctrl_res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_res_ready) begin
            r_out_valid <= ctrl_res_valid;
        end
        if (ctrl_res_ready && ctrl_res_valid) begin
            r_out <= ctrl_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.found_index   = r_out.found_index;
    assign o_res.removed_value = r_out.removed_value;
    assign o_res.list_length   = r_out.list_length;

endmodule

// ===== design/oal_checker.sv =====
// Port-level checks on the ordered array list, bound to the top level.
`timescale 1ns / 1ps

module oal_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input oal_pkg::t_status i_status,
    input oal_pkg::t_addr   i_found_index,
    input oal_pkg::t_data   i_removed_value,
    input oal_pkg::t_count  i_list_length
);

    // hold a stalled result unchanged
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_status)
            && $stable(i_found_index) && $stable(i_removed_value)
            && $stable(i_list_length))
        else $error("stalled result changed");

    // drop ready after a request is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while one is in flight");

    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_list_length <= oal_pkg::CAP_COUNT)
        else $error("list length beyond capacity");

    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status != oal_pkg::ST_OK
            |-> i_found_index == '0 && i_removed_value == '0)
        else $error("refused request returned data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result shown after reset");

endmodule

bind ordered_array_list oal_checker u_oal_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_status        (o_res.status),
    .i_found_index   (o_res.found_index),
    .i_removed_value (o_res.removed_value),
    .i_list_length   (o_res.list_length)
);
